// ===== src/rbm_pkg.sv =====
package rbm_pkg;

  localparam int XW = 14;
  localparam int QW = 12;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_BLOCK_DEF = 16;

  localparam logic [1:0] FMT_UYVY = 2'd1;
  localparam logic [1:0] FMT_PASS = 2'd2;

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH    = 3'd0,
    CFG_FRAME_HEIGHT   = 3'd1,
    CFG_REGION_LEFT    = 3'd2,
    CFG_REGION_TOP     = 3'd3,
    CFG_REGION_COLUMNS = 3'd4,
    CFG_REGION_LINES   = 3'd5,
    CFG_BLOCK_SIZE     = 3'd6,
    CFG_PIXEL_FORMAT   = 3'd7
  } cfg_index_t;

  typedef enum logic [3:0] {
    T_IDLE,
    T_PREP,
    T_OL_GO,
    T_OL_WAIT,
    T_OC_GO,
    T_OC_WAIT,
    T_EMIT,
    T_IL_GO,
    T_IL_WAIT,
    T_SUM,
    T_AVG,
    T_STORE,
    T_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_CHK,
    A_RD,
    A_ADD,
    A_MUL,
    A_GO,
    A_WAIT,
    A_WR
  } avg_state_t;

endpackage

// ===== src/rbm_div.sv =====
module rbm_div #(
  parameter int NW = 20,
  parameter int DW = 9,
  parameter int QW = rbm_pkg::QW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo,
  output logic [NW-1:0] rem
);

  localparam int TW = NW + DW + QW;
  localparam int IW = $clog2(QW);

  logic [NW-1:0] r;
  logic [DW-1:0] d;
  logic [QW-1:0] q;
  logic [IW-1:0] i;
  logic          run;
  logic [TW-1:0] sh;

  assign sh = TW'(d) << i;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        i   <= IW'(QW - 1);
        r   <= num;
        d   <= den;
        q   <= '0;
      end else if (run) begin
        if (TW'(r) >= sh) begin
          r    <= r - sh[NW-1:0];
          q[i] <= 1'b1;
        end
        if (i == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          i <= i - 1'b1;
        end
      end
    end
  end

  assign quo = q;
  assign rem = r;

endmodule

// ===== src/rbm_avg.sv =====
module rbm_avg #(
  parameter int MAX_WIDTH = rbm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BLOCK = rbm_pkg::MAX_BLOCK_DEF,
  parameter int NW = 20,
  parameter int DW = 9
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  output logic                                        busy,
  input  logic [rbm_pkg::XW-1:0]                      w_x,
  input  logic [rbm_pkg::XW-1:0]                      bs_x,
  input  logic [11:0]                                 rl,
  input  logic [11:0]                                 rc,
  input  logic [1:0]                                  fmt,
  input  logic [$clog2(MAX_WIDTH)-1:0]                sum_addr,
  input  logic                                        sum_we,
  input  logic [3*$clog2(MAX_BLOCK*255+1)-1:0]        sum_wdata,
  output logic [3*$clog2(MAX_BLOCK*255+1)-1:0]        sum_rdata,
  input  logic [$clog2(MAX_WIDTH)-1:0]                avg_addr,
  output logic [23:0]                                 avg_rdata,
  output logic                                        div_go,
  output logic [NW-1:0]                               div_num,
  output logic [DW-1:0]                               div_den,
  input  logic                                        div_done,
  input  logic [rbm_pkg::QW-1:0]                      div_quo
);

  localparam int XW  = rbm_pkg::XW;
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CSW = $clog2(MAX_BLOCK * 255 + 1);
  localparam int NBW = $clog2(MAX_BLOCK + 1);

  logic [3*CSW-1:0] sum_mem [MAX_WIDTH];
  logic [23:0]      avg_mem [MAX_WIDTH];

  rbm_pkg::avg_state_t state, state_next;

  logic [XW-1:0]  x0, c;
  logic [NW-1:0]  se, so, sb, sc;
  logic [NBW-1:0] ne, no;
  logic [2:0]     k;
  logic [7:0]     qv [5];
  logic [NW-1:0]  num;
  logic [DW-1:0]  den;
  logic [AW-1:0]  rd_a;
  logic           avg_we;
  logic [7:0]     qa;
  logic           chk_ok, col_last;

  assign busy    = (state != rbm_pkg::A_IDLE);
  assign rd_a    = busy ? c[AW-1:0] : sum_addr;
  assign chk_ok  = (x0 < XW'(rl) + XW'(rc)) && (x0 + bs_x <= w_x);
  assign col_last = (c + 1'b1 == x0 + bs_x);
  assign avg_we  = (state == rbm_pkg::A_WR);
  assign qa      = (fmt == rbm_pkg::FMT_UYVY) ? (c[0] ? qv[1] : qv[0]) : qv[2];
  assign div_go  = (state == rbm_pkg::A_GO);
  assign div_num = num;
  assign div_den = den;

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_addr] <= sum_wdata;
    end
    sum_rdata <= sum_mem[rd_a];
    if (avg_we) begin
      avg_mem[c[AW-1:0]] <= {qv[4], qv[3], qa};
    end
    avg_rdata <= avg_mem[avg_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbm_pkg::A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rbm_pkg::A_IDLE: if (start) state_next = rbm_pkg::A_CHK;
      rbm_pkg::A_CHK:  state_next = chk_ok ? rbm_pkg::A_RD : rbm_pkg::A_IDLE;
      rbm_pkg::A_RD:   state_next = rbm_pkg::A_ADD;
      rbm_pkg::A_ADD:  state_next = col_last ? rbm_pkg::A_MUL : rbm_pkg::A_RD;
      rbm_pkg::A_MUL:  state_next = rbm_pkg::A_GO;
      rbm_pkg::A_GO:   state_next = rbm_pkg::A_WAIT;
      rbm_pkg::A_WAIT: begin
        if (div_done) state_next = (k == 3'd4) ? rbm_pkg::A_WR : rbm_pkg::A_MUL;
      end
      rbm_pkg::A_WR:   if (col_last) state_next = rbm_pkg::A_CHK;
      default:         state_next = rbm_pkg::A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      rbm_pkg::A_IDLE: x0 <= XW'(rl);
      rbm_pkg::A_CHK: begin
        c  <= x0;
        se <= '0;
        so <= '0;
        sb <= '0;
        sc <= '0;
        ne <= '0;
        no <= '0;
      end
      rbm_pkg::A_ADD: begin
        if (c[0]) begin
          so <= so + NW'(sum_rdata[CSW-1:0]);
          no <= no + 1'b1;
        end else begin
          se <= se + NW'(sum_rdata[CSW-1:0]);
          ne <= ne + 1'b1;
        end
        sb <= sb + NW'(sum_rdata[2*CSW-1:CSW]);
        sc <= sc + NW'(sum_rdata[3*CSW-1:2*CSW]);
        if (col_last) begin
          k <= 3'd0;
        end else begin
          c <= c + 1'b1;
        end
      end
      rbm_pkg::A_MUL: begin
        case (k)
          3'd0: begin
            num <= se;
            den <= DW'(DW'(bs_x) * DW'(ne));
          end
          3'd1: begin
            num <= so;
            den <= DW'(DW'(bs_x) * DW'(no));
          end
          3'd2: begin
            num <= se + so;
            den <= DW'(DW'(bs_x) * DW'(bs_x));
          end
          3'd3: begin
            num <= sb;
            den <= DW'(DW'(bs_x) * DW'(bs_x));
          end
          default: begin
            num <= sc;
            den <= DW'(DW'(bs_x) * DW'(bs_x));
          end
        endcase
      end
      rbm_pkg::A_WAIT: begin
        if (div_done) begin
          qv[k] <= div_quo[7:0];
          if (k == 3'd4) begin
            c <= x0;
          end else begin
            k <= k + 1'b1;
          end
        end
      end
      rbm_pkg::A_WR: begin
        if (col_last) begin
          x0 <= x0 + bs_x;
        end else begin
          c <= c + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/region_block_mosaic_filter.sv =====
// region block mosaic filter
// pixels enter on the s_ channel in raster order, one per request; tuser 0 is a
// pixel, tuser 1 asks for one delayed pixel to be drained (flush)
// results leave on the m_ channel; tlast marks the last pixel of a frame
// the output trails the input by block_size lines held in a ring of
// MAX_WIDTH * MAX_BLOCK pixels; inside the region each block is replaced by its
// component averages (rgb: three bytes, uyvy: luma and per-parity chroma)
// a pixel request that also emits runs three divisions, and inside a band it
// also updates the column sums; while the ring fills it runs one division:
// the band and block positions are divisions on one shared
// bit-serial divider, one quotient bit per cycle
// the last pixel of a band adds, per block, a check, the column sums, five
// divisions and the writes of the block's averages
// a flush request runs two divisions; a flush with nothing held emits nothing
// s_tready is high only while no request is in work
// a finished result sits in a pending register; the next request is taken once
// that result has moved to the output register, which holds while m_tready is low
// reset (rst, synchronous) loads the register defaults and empties the ring
// config writes (cfg_we, cfg_index, cfg_data) take effect at once; write when idle
module region_block_mosaic_filter #(
  parameter int MAX_WIDTH = rbm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BLOCK = rbm_pkg::MAX_BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // comp_a, comp_b, comp_c
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_a, out_b, out_c
  output logic        m_tlast
);

  localparam int XW    = rbm_pkg::XW;
  localparam int QW    = rbm_pkg::QW;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = AW + 1;
  localparam int DEPTH = MAX_WIDTH * MAX_BLOCK;
  localparam int PW    = $clog2(DEPTH);
  localparam int HW    = $clog2(DEPTH + 1);
  localparam int CSW   = $clog2(MAX_BLOCK * 255 + 1);
  localparam int SW    = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
  localparam int NW    = (SW > XW) ? SW : XW;
  localparam int DW    = $clog2(MAX_BLOCK * MAX_BLOCK + 1);

  logic [10:0] fw;
  logic [11:0] fh, rl, rt, rc, rln;
  logic [4:0]  bsz;
  logic [1:0]  fmt;

  logic [XW-1:0]   w_x, h_x, bs_x;
  logic [2*XW-1:0] delay;

  rbm_pkg::top_state_t state, state_next;

  logic          it_kind;
  logic [23:0]   it_px;
  logic          direct;
  logic [CW-1:0] in_col, out_col;
  logic [11:0]   in_line, out_line;
  logic [PW-1:0] rd_pos, wr_pos;
  logic [HW-1:0] held;
  logic [XW-1:0] ry, rx, roff;
  logic [23:0]   res_data;
  logic          res_last, res_pend;

  logic [23:0] line_mem [DEPTH];
  logic [23:0] line_rd;
  logic        store_we;

  logic          t_go;
  logic [NW-1:0] t_num;
  logic          a_go, d_go, d_done;
  logic [NW-1:0] a_num, d_num, d_rem;
  logic [DW-1:0] a_den, d_den;
  logic [QW-1:0] d_quo;

  logic             avg_start, avg_busy, sum_we;
  logic [3*CSW-1:0] sum_wdata, sum_rdata;
  logic [23:0]      avg_rdata;

  logic [XW-1:0] y0o, x0o, y0i, oc_x, il_x, rem_x;
  logic          blk, band_i, oc_last, ol_last, ic_last, band_last, out_step, out_free;
  logic [23:0]   emit_px;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      fw  <= 11'd1024;
      fh  <= 12'd1080;
      rl  <= '0;
      rt  <= '0;
      rc  <= '0;
      rln <= '0;
      bsz <= 5'd8;
      fmt <= '0;
    end else if (cfg_we) begin
      case (rbm_pkg::cfg_index_t'(cfg_index))
        rbm_pkg::CFG_FRAME_WIDTH:    fw  <= cfg_data[10:0];
        rbm_pkg::CFG_FRAME_HEIGHT:   fh  <= cfg_data;
        rbm_pkg::CFG_REGION_LEFT:    rl  <= cfg_data;
        rbm_pkg::CFG_REGION_TOP:     rt  <= cfg_data;
        rbm_pkg::CFG_REGION_COLUMNS: rc  <= cfg_data;
        rbm_pkg::CFG_REGION_LINES:   rln <= cfg_data;
        rbm_pkg::CFG_BLOCK_SIZE:     bsz <= cfg_data[4:0];
        rbm_pkg::CFG_PIXEL_FORMAT:   fmt <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign w_x   = (fw == '0) ? XW'(1) :
                 ((XW'(fw) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(fw));
  assign h_x   = (fh == '0) ? XW'(1) : XW'(fh);
  assign bs_x  = (XW'(bsz) > XW'(MAX_BLOCK)) ? XW'(MAX_BLOCK) : XW'(bsz);
  assign delay = (2*XW)'(bs_x) * (2*XW)'(w_x);

  // shared divider
  assign d_go  = avg_busy ? a_go : t_go;
  assign d_num = avg_busy ? a_num : t_num;
  assign d_den = avg_busy ? a_den : DW'(bs_x);

  rbm_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (d_go),
    .num  (d_num),
    .den  (d_den),
    .done (d_done),
    .quo  (d_quo),
    .rem  (d_rem)
  );

  rbm_avg #(.MAX_WIDTH(MAX_WIDTH), .MAX_BLOCK(MAX_BLOCK), .NW(NW), .DW(DW)) u_avg (
    .clk       (clk),
    .rst       (rst),
    .start     (avg_start),
    .busy      (avg_busy),
    .w_x       (w_x),
    .bs_x      (bs_x),
    .rl        (rl),
    .rc        (rc),
    .fmt       (fmt),
    .sum_addr  (in_col[AW-1:0]),
    .sum_we    (sum_we),
    .sum_wdata (sum_wdata),
    .sum_rdata (sum_rdata),
    .avg_addr  (out_col[AW-1:0]),
    .avg_rdata (avg_rdata),
    .div_go    (a_go),
    .div_num   (a_num),
    .div_den   (a_den),
    .div_done  (d_done),
    .div_quo   (d_quo)
  );

  // delay ring
  always_ff @(posedge clk) begin
    if (store_we) begin
      line_mem[wr_pos] <= it_px;
    end
    line_rd <= line_mem[rd_pos];
  end

  // position checks
  assign rem_x   = d_rem[XW-1:0];
  assign oc_x    = XW'(out_col);
  assign il_x    = XW'(in_line);
  assign y0o     = XW'(out_line) - ry;
  assign x0o     = oc_x - rx;
  assign y0i     = il_x - rem_x;
  assign oc_last = (oc_x + 1'b1 >= w_x);
  assign ol_last = (XW'(out_line) + 1'b1 >= h_x);
  assign ic_last = (XW'(in_col) + 1'b1 >= w_x);
  assign blk = (fmt < rbm_pkg::FMT_PASS) && (bs_x != '0) &&
               (XW'(out_line) >= XW'(rt)) && (y0o < XW'(rt) + XW'(rln)) &&
               (y0o + bs_x <= h_x) &&
               (XW'(rl) < w_x) && (oc_x >= XW'(rl)) &&
               (x0o < XW'(rl) + XW'(rc)) && (x0o + bs_x <= w_x) &&
               (oc_x < XW'(MAX_WIDTH));
  assign band_i = (bs_x != '0) && (il_x >= XW'(rt)) && (y0i < XW'(rt) + XW'(rln)) &&
                  (y0i + bs_x <= h_x) && (XW'(in_col) < XW'(MAX_WIDTH));
  assign band_last = (roff + 1'b1 == bs_x) && ic_last;
  assign emit_px = blk ? avg_rdata : line_rd;
  assign out_step = (state == rbm_pkg::T_EMIT) || ((state == rbm_pkg::T_STORE) && direct);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (roff == '0) begin
        sum_wdata[k*CSW +: CSW] = CSW'(it_px[k*8 +: 8]);
      end else begin
        sum_wdata[k*CSW +: CSW] = sum_rdata[k*CSW +: CSW] + CSW'(it_px[k*8 +: 8]);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbm_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    t_go       = 1'b0;
    t_num      = NW'(il_x - XW'(rt));
    sum_we     = 1'b0;
    avg_start  = 1'b0;
    store_we   = 1'b0;
    case (state)
      rbm_pkg::T_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = rbm_pkg::T_PREP;
      end
      rbm_pkg::T_PREP: begin
        if (it_kind) begin
          state_next = (held == '0) ? rbm_pkg::T_IDLE : rbm_pkg::T_OL_GO;
        end else if ((held != '0) && ((2*XW)'(held) >= delay)) begin
          state_next = rbm_pkg::T_OL_GO;
        end else begin
          state_next = rbm_pkg::T_IL_GO;
        end
      end
      rbm_pkg::T_OL_GO: begin
        t_go       = 1'b1;
        t_num      = NW'(XW'(out_line) - XW'(rt));
        state_next = rbm_pkg::T_OL_WAIT;
      end
      rbm_pkg::T_OL_WAIT: if (d_done) state_next = rbm_pkg::T_OC_GO;
      rbm_pkg::T_OC_GO: begin
        t_go       = 1'b1;
        t_num      = NW'(oc_x - XW'(rl));
        state_next = rbm_pkg::T_OC_WAIT;
      end
      rbm_pkg::T_OC_WAIT: if (d_done) state_next = rbm_pkg::T_EMIT;
      rbm_pkg::T_EMIT: state_next = it_kind ? rbm_pkg::T_OUT : rbm_pkg::T_IL_GO;
      rbm_pkg::T_IL_GO: begin
        t_go       = 1'b1;
        state_next = rbm_pkg::T_IL_WAIT;
      end
      rbm_pkg::T_IL_WAIT: begin
        if (d_done) state_next = band_i ? rbm_pkg::T_SUM : rbm_pkg::T_STORE;
      end
      rbm_pkg::T_SUM: begin
        sum_we = 1'b1;
        if (band_last) begin
          avg_start  = 1'b1;
          state_next = rbm_pkg::T_AVG;
        end else begin
          state_next = rbm_pkg::T_STORE;
        end
      end
      rbm_pkg::T_AVG: if (!avg_busy) state_next = rbm_pkg::T_STORE;
      rbm_pkg::T_STORE: begin
        store_we   = !direct;
        state_next = rbm_pkg::T_OUT;
      end
      rbm_pkg::T_OUT: if (!res_pend || out_free) state_next = rbm_pkg::T_IDLE;
      default: state_next = rbm_pkg::T_IDLE;
    endcase
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (state == rbm_pkg::T_IDLE) begin
      it_kind <= s_tuser;
      it_px   <= s_tdata;
    end
    if (state == rbm_pkg::T_PREP) begin
      direct <= (held == '0) && (delay == '0);
    end
    if (state == rbm_pkg::T_OL_WAIT && d_done) ry <= rem_x;
    if (state == rbm_pkg::T_OC_WAIT && d_done) rx <= rem_x;
    if (state == rbm_pkg::T_IL_WAIT && d_done) roff <= rem_x;
    if (state == rbm_pkg::T_EMIT) begin
      res_data <= (fmt == rbm_pkg::FMT_UYVY) ? {8'd0, emit_px[15:0]} : emit_px;
      res_last <= oc_last && ol_last;
    end
    if (state == rbm_pkg::T_STORE && direct) begin
      res_data <= (fmt == rbm_pkg::FMT_UYVY) ? {8'd0, it_px[15:0]} : it_px;
      res_last <= oc_last && ol_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col   <= '0;
      in_line  <= '0;
      out_col  <= '0;
      out_line <= '0;
      rd_pos   <= '0;
      wr_pos   <= '0;
      held     <= '0;
      res_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_step) begin
        res_pend <= 1'b1;
        if (oc_last) begin
          out_col  <= '0;
          out_line <= ol_last ? '0 : out_line + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
      if (state == rbm_pkg::T_EMIT) begin
        rd_pos <= (rd_pos == PW'(DEPTH - 1)) ? '0 : rd_pos + 1'b1;
        held   <= held - 1'b1;
      end
      if (state == rbm_pkg::T_STORE) begin
        if (!direct) begin
          wr_pos <= (wr_pos == PW'(DEPTH - 1)) ? '0 : wr_pos + 1'b1;
          held   <= held + 1'b1;
        end
        if (ic_last) begin
          in_col  <= '0;
          in_line <= (il_x + 1'b1 >= h_x) ? '0 : in_line + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (state == rbm_pkg::T_OUT && res_pend && out_free) begin
        res_pend <= 1'b0;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rbm_pkg::T_OUT && res_pend && out_free) begin
      m_tdata <= res_data;
      m_tlast <= res_last;
    end
  end

endmodule

// ===== src/rbm_chk.sv =====
module rbm_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while one is in work");

endmodule

bind region_block_mosaic_filter rbm_chk u_rbm_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
